>>> design/ipg_pkg.sv
// Shared types and constants for the Ives permutation generator.
// Holds the sequencer step, micro-operation and branch condition codes
// and the control/status structs; depends on nothing.
package ipg_pkg;

   localparam int MAX_ELEMENTS = 16;
   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int SIZE_W = $clog2(MAX_ELEMENTS + 1);
   localparam int MIN_SIZE = 2;
   localparam int SIZE_RESET = 4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_SCAN,
      S_RDA,
      S_RDB,
      S_WRA,
      S_ERD,
      S_EOUT,
      S_EXH
   } pc_type;

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_FILL,
      OP_SCAN,
      OP_RDA,
      OP_RDB,
      OP_WRA,
      OP_ERD,
      OP_EOUT,
      OP_EXH
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_FRESH,
      COND_FILL_MORE,
      COND_SCAN_OVER,
      COND_HOME,
      COND_EMIT_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      uop_type  op;
      cond_type hold_sel;
      cond_type jump_sel;
      pc_type   jump_pc;
      pc_type   next_pc;
   } ucode_type;

   typedef struct packed {
      logic no_req;
      logic fresh;
      logic fill_more;
      logic scan_over;
      logic home;
      logic emit_more;
      logic out_busy;
   } status_type;

endpackage

>>> design/ipg_sequencer.sv
// Microcode sequencer: step counter, control store and branch logic.
// Uses ipg_pkg; status flags come from ipg_datapath.
module ipg_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  ipg_pkg::status_type status,
   output ipg_pkg::uop_type    op
);
   import ipg_pkg::*;

   pc_type    pc_ff;
   pc_type    pc_in;
   ucode_type word;
   logic      hold;
   logic      jump;

   function automatic ucode_type control_store(input pc_type pc);
      ucode_type w;
      w = '{op: OP_WAIT, hold_sel: COND_NO_REQ, jump_sel: COND_FRESH,
            jump_pc: S_FILL, next_pc: S_SCAN};
      case (pc)
         S_IDLE: w = '{op: OP_WAIT, hold_sel: COND_NO_REQ, jump_sel: COND_FRESH,
                       jump_pc: S_FILL, next_pc: S_SCAN};
         S_FILL: w = '{op: OP_FILL, hold_sel: COND_FILL_MORE, jump_sel: COND_NEVER,
                       jump_pc: S_IDLE, next_pc: S_ERD};
         S_SCAN: w = '{op: OP_SCAN, hold_sel: COND_NEVER, jump_sel: COND_SCAN_OVER,
                       jump_pc: S_EXH, next_pc: S_RDA};
         S_RDA:  w = '{op: OP_RDA, hold_sel: COND_NEVER, jump_sel: COND_NEVER,
                       jump_pc: S_IDLE, next_pc: S_RDB};
         S_RDB:  w = '{op: OP_RDB, hold_sel: COND_NEVER, jump_sel: COND_NEVER,
                       jump_pc: S_IDLE, next_pc: S_WRA};
         S_WRA:  w = '{op: OP_WRA, hold_sel: COND_NEVER, jump_sel: COND_HOME,
                       jump_pc: S_SCAN, next_pc: S_ERD};
         S_ERD:  w = '{op: OP_ERD, hold_sel: COND_NEVER, jump_sel: COND_NEVER,
                       jump_pc: S_IDLE, next_pc: S_EOUT};
         S_EOUT: w = '{op: OP_EOUT, hold_sel: COND_EMIT_MORE, jump_sel: COND_NEVER,
                       jump_pc: S_IDLE, next_pc: S_IDLE};
         S_EXH:  w = '{op: OP_EXH, hold_sel: COND_OUT_BUSY, jump_sel: COND_NEVER,
                       jump_pc: S_IDLE, next_pc: S_IDLE};
         default: w = '{op: OP_WAIT, hold_sel: COND_NO_REQ, jump_sel: COND_FRESH,
                        jump_pc: S_FILL, next_pc: S_SCAN};
      endcase
      return w;
   endfunction

   function automatic logic test(input cond_type c, input status_type s);
      logic r;
      r = 1'b0;
      case (c)
         COND_NEVER:     r = 1'b0;
         COND_NO_REQ:    r = s.no_req;
         COND_FRESH:     r = s.fresh;
         COND_FILL_MORE: r = s.fill_more;
         COND_SCAN_OVER: r = s.scan_over;
         COND_HOME:      r = s.home;
         COND_EMIT_MORE: r = s.emit_more;
         COND_OUT_BUSY:  r = s.out_busy;
         default:        r = 1'b0;
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      word = control_store(pc_ff);
      hold = test(word.hold_sel, status);
      jump = test(word.jump_sel, status);
      op = word.op;
      if (hold) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = word.jump_pc;
      end else begin
         pc_in = word.next_pc;
      end
   end

endmodule

>>> design/ipg_datapath.sv
// Datapath: permutation memory, level counters, scan registers and the
// output register. Uses ipg_pkg; driven one micro-operation per cycle.
module ipg_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ipg_pkg::uop_type    op,
   output ipg_pkg::status_type status,
   input  logic                req_valid,
   input  logic                req_restart,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_element,
   output logic                rsp_is_last,
   output logic                rsp_sign_negative,
   output logic                rsp_exhausted,
   input  logic                csr_write_enable,
   input  logic [4:0]          csr_size_in_use
);
   import ipg_pkg::*;

   logic [IDX_W-1:0]  perm_mem [MAX_ELEMENTS];
   logic [IDX_W-1:0]  cnt_ff [MAX_ELEMENTS];
   logic [IDX_W-1:0]  cnt_in [MAX_ELEMENTS];

   logic [4:0]        size_ff;
   logic [SIZE_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  a_ff, a_in;
   logic [IDX_W-1:0]  b_ff, b_in;
   logic [IDX_W-1:0]  ta_ff, ta_in;
   logic [IDX_W-1:0]  rd_ff;
   logic              tail_ff, tail_in;
   logic              parity_ff, parity_in;
   logic              started_ff, started_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_element_ff, rsp_element_in;
   logic              rsp_is_last_ff, rsp_is_last_in;
   logic              rsp_sign_ff, rsp_sign_in;
   logic              rsp_exh_ff, rsp_exh_in;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa, mem_wd, mem_ra;

   logic              go, fresh, out_free, load, last_elem;
   logic [SIZE_W-1:0] lim_full, n_less1, size_clamped;
   logic [IDX_W-1:0]  lim, cnt_cur, k_next;
   logic              scan_over, cnt_below, home;

   always_comb begin
      n_less1 = n_ff - SIZE_W'(1);
      lim_full = n_less1 - SIZE_W'(i_ff);
      lim = lim_full[IDX_W-1:0];
      cnt_cur = cnt_ff[i_ff];
      k_next = k_ff + IDX_W'(1);
      last_elem = (SIZE_W'(k_ff) == n_less1);
      scan_over = (SIZE_W'(i_ff) >= lim_full);
      cnt_below = (cnt_cur < lim);
      home = tail_ff && (ta_ff == b_ff);
      fresh = req_restart || !started_ff;
      go = (op == OP_WAIT) && req_valid;
      out_free = !rsp_valid_ff || !rsp_stall;
      if (size_ff < 5'(MIN_SIZE)) begin
         size_clamped = SIZE_W'(MIN_SIZE);
      end else if (size_ff > 5'(MAX_ELEMENTS)) begin
         size_clamped = SIZE_W'(MAX_ELEMENTS);
      end else begin
         size_clamped = SIZE_W'(size_ff);
      end
   end

   always_comb begin
      n_in = n_ff;
      i_in = i_ff;
      k_in = k_ff;
      a_in = a_ff;
      b_in = b_ff;
      ta_in = ta_ff;
      tail_in = tail_ff;
      parity_in = parity_ff;
      started_in = started_ff;
      cnt_in = cnt_ff;
      mem_we = 1'b0;
      mem_wa = k_ff;
      mem_wd = k_ff;
      mem_ra = k_ff;
      load = 1'b0;
      rsp_element_in = rsp_element_ff;
      rsp_is_last_in = rsp_is_last_ff;
      rsp_sign_in = rsp_sign_ff;
      rsp_exh_in = rsp_exh_ff;

      case (op)
         OP_WAIT: begin
            if (go) begin
               if (fresh) begin
                  n_in = size_clamped;
                  parity_in = 1'b0;
                  started_in = 1'b1;
                  k_in = '0;
                  for (int j = 0; j < MAX_ELEMENTS; j++) begin
                     cnt_in[j] = IDX_W'(j);
                  end
               end else begin
                  i_in = '0;
               end
            end
         end
         OP_FILL: begin
            mem_we = 1'b1;
            mem_wa = k_ff;
            mem_wd = k_ff;
            k_in = last_elem ? '0 : k_next;
         end
         OP_SCAN: begin
            if (!scan_over) begin
               if (cnt_below) begin
                  a_in = cnt_cur;
                  b_in = cnt_cur + IDX_W'(1);
                  cnt_in[i_ff] = cnt_cur + IDX_W'(1);
                  tail_in = 1'b0;
               end else begin
                  // End swap of the level; the counter returns to its home.
                  a_in = i_ff;
                  b_in = lim;
                  cnt_in[i_ff] = i_ff;
                  tail_in = 1'b1;
               end
            end
         end
         OP_RDA: begin
            mem_ra = a_ff;
         end
         OP_RDB: begin
            // The read returns the old entry at b while it is overwritten.
            mem_ra = b_ff;
            mem_we = 1'b1;
            mem_wa = b_ff;
            mem_wd = rd_ff;
            ta_in = rd_ff;
         end
         OP_WRA: begin
            mem_we = 1'b1;
            mem_wa = a_ff;
            mem_wd = rd_ff;
            parity_in = !parity_ff;
            k_in = '0;
            if (home) begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         OP_ERD: begin
            mem_ra = k_ff;
         end
         OP_EOUT: begin
            if (out_free) begin
               load = 1'b1;
               rsp_element_in = rd_ff;
               rsp_is_last_in = last_elem;
               rsp_sign_in = parity_ff;
               rsp_exh_in = 1'b0;
               k_in = k_next;
               mem_ra = k_next;
            end else begin
               mem_ra = k_ff;
            end
         end
         OP_EXH: begin
            if (out_free) begin
               load = 1'b1;
               rsp_element_in = '0;
               rsp_is_last_in = 1'b1;
               rsp_sign_in = 1'b0;
               rsp_exh_in = 1'b1;
               started_in = 1'b0;
            end
         end
         default: begin
            mem_ra = k_ff;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= perm_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 5'(SIZE_RESET);
         n_ff <= SIZE_W'(SIZE_RESET);
         parity_ff <= 1'b0;
         started_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tail_ff <= 1'b0;
         for (int j = 0; j < MAX_ELEMENTS; j++) begin
            cnt_ff[j] <= IDX_W'(j);
         end
      end else begin
         if (csr_write_enable) begin
            size_ff <= csr_size_in_use;
         end
         n_ff <= n_in;
         parity_ff <= parity_in;
         started_ff <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         tail_ff <= tail_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      k_ff <= k_in;
      a_ff <= a_in;
      b_ff <= b_in;
      ta_ff <= ta_in;
      rsp_element_ff <= rsp_element_in;
      rsp_is_last_ff <= rsp_is_last_in;
      rsp_sign_ff <= rsp_sign_in;
      rsp_exh_ff <= rsp_exh_in;
   end

   assign status.no_req = !req_valid;
   assign status.fresh = fresh;
   assign status.fill_more = !last_elem;
   assign status.scan_over = scan_over;
   assign status.home = home;
   assign status.emit_more = !(out_free && last_elem);
   assign status.out_busy = !out_free;

   assign req_stall = (op != OP_WAIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_is_last = rsp_is_last_ff;
   assign rsp_sign_negative = rsp_sign_ff;
   assign rsp_exhausted = rsp_exh_ff;

endmodule

>>> design/ives_permutation_generator.sv
// Ives permutation generator. Each request either restarts from the identity
// (restart set, first request, or the request after exhaustion) or advances
// to the next permutation in Ives order, then streams the n elements one per
// result, carrying the parity and marking the last one; after the final
// permutation one result flagged exhausted is returned. The size register is
// sampled when a sequence begins. A restart takes an accept step, fills the
// permutation memory with the identity, does a read-ahead and then outputs
// the elements; an advance takes an accept step, then visits one or more
// levels, each costing a counter test and a swap through the memory (read a,
// read b while writing b, write a), then reads ahead and outputs; the
// exhausted request takes an accept step, the levels, one final scan test and
// the exhausted result. One element leaves per cycle while the output is not
// stalled.
module ives_permutation_generator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_element,
   output logic       rsp_is_last,
   output logic       rsp_sign_negative,
   output logic       rsp_exhausted,
   input  logic       csr_write_enable,
   input  logic [4:0] csr_size_in_use
);
   import ipg_pkg::*;

   uop_type    op;
   status_type status;

   ipg_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   ipg_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .req_valid         (req_valid),
      .req_restart       (req_restart),
      .req_stall         (req_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element       (rsp_element),
      .rsp_is_last       (rsp_is_last),
      .rsp_sign_negative (rsp_sign_negative),
      .rsp_exhausted     (rsp_exhausted),
      .csr_write_enable  (csr_write_enable),
      .csr_size_in_use   (csr_size_in_use)
   );

endmodule

>>> design/ipg_checker.sv
// Port-level checks for the Ives permutation generator, bound to the top.
// Sees only the top-level ports; uses no package.
module ipg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_element,
   input logic       rsp_is_last,
   input logic       rsp_sign_negative,
   input logic       rsp_exhausted
);

   // A held result keeps its element and its last and exhausted flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element)
         && $stable(rsp_is_last) && $stable(rsp_exhausted))
      else $error("stalled result changed");

   // The exhausted marker is a final, empty result with a positive sign.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exhausted |-> rsp_is_last && rsp_element == 4'd0
         && !rsp_sign_negative)
      else $error("malformed exhausted result");

   // Once a request is taken the block is busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted twice in a row");

endmodule

bind ives_permutation_generator ipg_checker u_ipg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_element       (rsp_element),
   .rsp_is_last       (rsp_is_last),
   .rsp_sign_negative (rsp_sign_negative),
   .rsp_exhausted     (rsp_exhausted)
);
